[design/nnsag_pkg.sv]
// ----------------------------------------------------------------------------
// nnsag_pkg
// Shared types, register codes and reset values of the nearest-neighbor
// scaler address generator.
// ----------------------------------------------------------------------------
package nnsag_pkg;

	localparam int unsigned MAX_DIM_DEF   = 4096;
	localparam int unsigned ADDR_BITS_DEF = 24;

	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 25;

	localparam int unsigned DIM_W  = 13;
	localparam int unsigned REM_W  = 12;
	localparam int unsigned SKIP_W = 25;
	localparam int unsigned OFS_W  = 24;
	localparam int unsigned OUT_W  = 24;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP_WHOLE = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP_REM   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_SKIP     = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP_REM   = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = CFG_IDX_W'(7);

	localparam logic [DIM_W-1:0]         RST_SRC_WIDTH    = DIM_W'(160);
	localparam logic [DIM_W-1:0]         RST_DST_WIDTH    = DIM_W'(160);
	localparam logic [DIM_W-1:0]         RST_DST_HEIGHT   = DIM_W'(144);
	localparam logic [DIM_W-1:0]         RST_X_STEP_WHOLE = DIM_W'(1);
	localparam logic [REM_W-1:0]         RST_X_STEP_REM   = '0;
	localparam logic signed [SKIP_W-1:0] RST_ROW_SKIP     = '0;
	localparam logic [REM_W-1:0]         RST_Y_STEP_REM   = '0;
	localparam logic [OFS_W-1:0]         RST_START_OFFSET = '0;

	typedef struct packed {
		logic [DIM_W-1:0]         src_width;
		logic [DIM_W-1:0]         dst_width;
		logic [DIM_W-1:0]         dst_height;
		logic [DIM_W-1:0]         x_step_whole;
		logic [REM_W-1:0]         x_step_rem;
		logic signed [SKIP_W-1:0] row_skip;
		logic [REM_W-1:0]         y_step_rem;
		logic [OFS_W-1:0]         start_offset;
	} nnsag_cfg_t;

	typedef struct packed {
		logic restart;
	} nnsag_item_t;

	typedef struct packed {
		logic        valid;
		nnsag_item_t item;
	} nnsag_head_t;

endpackage

[design/nnsag_ifs.sv]
// ----------------------------------------------------------------------------
// nnsag channel interfaces
// Request, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nnsag_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface nnsag_out_if import nnsag_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] src_address;
	logic [OUT_W-1:0] dst_index;
	logic             row_end;
	logic             last;

	modport source (output valid, output src_address, output dst_index, output row_end,
		output last, input ready);
	modport sink (input valid, input src_address, input dst_index, input row_end,
		input last, output ready);
endinterface

interface nnsag_cfg_if import nnsag_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/nnsag_queue.sv]
// ----------------------------------------------------------------------------
// nnsag_queue
// Front end: accepts request beats and holds them in a short queue for the
// step engine.
// ----------------------------------------------------------------------------
module nnsag_queue import nnsag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nnsag_in_if.sink    req,
	input  logic        pop,
	output nnsag_head_t head
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	nnsag_item_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              do_pop;
	nnsag_item_t       item_in;

	assign req.ready       = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push            = req.valid && req.ready;
	assign do_pop          = pop && (count_q != '0);
	assign item_in.restart = req.restart;

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/nnsag_step.sv]
// ----------------------------------------------------------------------------
// nnsag_step
// Back end: walks the destination frame one pixel per beat, steps the
// source offset with the remainder accumulators and registers the result.
// ----------------------------------------------------------------------------
module nnsag_step import nnsag_pkg::*; #(
	parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
	parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  nnsag_cfg_t  cfg,
	input  nnsag_head_t head,
	output logic        pop,
	nnsag_out_if.source rsp
);

	localparam int unsigned DW_BITS = $clog2(MAX_DIM + 1);
	localparam int unsigned CNT_W   = $clog2(MAX_DIM);
	localparam int unsigned ACC_W   = DW_BITS + 1;

	logic [CNT_W-1:0]     column_left_q;
	logic [CNT_W-1:0]     row_left_q;
	logic [CNT_W-1:0]     x_error_q;
	logic [CNT_W-1:0]     y_error_q;
	logic [ADDR_BITS-1:0] source_offset_q;
	logic [ADDR_BITS-1:0] dest_counter_q;
	logic                 frame_active_q;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_src_address_q;
	logic [OUT_W-1:0]     out_dst_index_q;
	logic                 out_row_end_q;
	logic                 out_last_q;

	logic [DW_BITS-1:0]   dw;
	logic [DW_BITS-1:0]   dh;
	logic [CNT_W-1:0]     dw_m1;
	logic [CNT_W-1:0]     dh_m1;
	logic [CNT_W-1:0]     xr;
	logic [CNT_W-1:0]     yr;

	logic                 take;
	logic                 start;
	logic [CNT_W-1:0]     cl0;
	logic [CNT_W-1:0]     rl0;
	logic [CNT_W-1:0]     xe0;
	logic [CNT_W-1:0]     ye0;
	logic [CNT_W-1:0]     cl1;
	logic [CNT_W-1:0]     rl1;
	logic [CNT_W-1:0]     xe1;
	logic [CNT_W-1:0]     ye1;
	logic [ADDR_BITS-1:0] so1;
	logic [ADDR_BITS-1:0] dc1;
	logic                 row_end;
	logic                 last;

	logic [ACC_W-1:0]     xs;
	logic [ACC_W-1:0]     ys;
	logic                 xc;
	logic                 yc;
	logic [CNT_W-1:0]     xe_adv;
	logic [CNT_W-1:0]     ye_adv;
	logic [ADDR_BITS-1:0] so_x;
	logic [ADDR_BITS-1:0] so_row;

	// effective frame size and remainders
	always_comb begin
		if (cfg.dst_width == '0) begin
			dw = DW_BITS'(1);
		end else if (32'(cfg.dst_width) > MAX_DIM) begin
			dw = DW_BITS'(MAX_DIM);
		end else begin
			dw = DW_BITS'(cfg.dst_width);
		end
		if (cfg.dst_height == '0) begin
			dh = DW_BITS'(1);
		end else if (32'(cfg.dst_height) > MAX_DIM) begin
			dh = DW_BITS'(MAX_DIM);
		end else begin
			dh = DW_BITS'(cfg.dst_height);
		end
		dw_m1 = CNT_W'(dw - DW_BITS'(1));
		dh_m1 = CNT_W'(dh - DW_BITS'(1));
		xr = (32'(cfg.x_step_rem) >= 32'(dw)) ? dw_m1 : CNT_W'(cfg.x_step_rem);
		yr = (32'(cfg.y_step_rem) >= 32'(dh)) ? dh_m1 : CNT_W'(cfg.y_step_rem);
	end

	assign take = head.valid && (!out_valid_q || rsp.ready);
	assign pop  = take;

	always_comb begin
		start = head.item.restart || !frame_active_q;
		cl0   = start ? dw_m1 : column_left_q;
		rl0   = start ? dh_m1 : row_left_q;
		xe0   = start ? '0 : x_error_q;
		ye0   = start ? '0 : y_error_q;
		so1   = start ? ADDR_BITS'(cfg.start_offset) : source_offset_q;
		dc1   = start ? '0 : dest_counter_q;

		cl1 = (DW_BITS'(cl0) >= dw) ? dw_m1 : cl0;
		rl1 = (DW_BITS'(rl0) >= dh) ? dh_m1 : rl0;
		xe1 = (DW_BITS'(xe0) >= dw) ? '0 : xe0;
		ye1 = (DW_BITS'(ye0) >= dh) ? '0 : ye0;

		row_end = (cl1 == '0);
		last    = row_end && (rl1 == '0);

		xs     = ACC_W'(xe1) + ACC_W'(xr);
		xc     = (xs >= ACC_W'(dw));
		xe_adv = xc ? CNT_W'(xs - ACC_W'(dw)) : CNT_W'(xs);
		ys     = ACC_W'(ye1) + ACC_W'(yr);
		yc     = (ys >= ACC_W'(dh));
		ye_adv = yc ? CNT_W'(ys - ACC_W'(dh)) : CNT_W'(ys);

		so_x   = so1 + ADDR_BITS'(cfg.x_step_whole) + ADDR_BITS'(xc);
		so_row = so_x + ADDR_BITS'($signed(cfg.row_skip))
			+ (yc ? ADDR_BITS'(cfg.src_width) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_left_q   <= '0;
			row_left_q      <= '0;
			x_error_q       <= '0;
			y_error_q       <= '0;
			source_offset_q <= '0;
			dest_counter_q  <= '0;
			frame_active_q  <= 1'b0;
		end else if (take) begin
			dest_counter_q <= dc1 + 1'b1;
			frame_active_q <= !last;
			if (row_end) begin
				column_left_q   <= dw_m1;
				x_error_q       <= '0;
				y_error_q       <= ye_adv;
				source_offset_q <= so_row;
				row_left_q      <= (rl1 != '0) ? rl1 - 1'b1 : rl1;
			end else begin
				column_left_q   <= cl1 - 1'b1;
				x_error_q       <= xe_adv;
				y_error_q       <= ye1;
				source_offset_q <= so_x;
				row_left_q      <= rl1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_src_address_q <= OUT_W'(so1);
			out_dst_index_q   <= OUT_W'(dc1);
			out_row_end_q     <= row_end;
			out_last_q        <= last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.src_address = out_src_address_q;
	assign rsp.dst_index   = out_dst_index_q;
	assign rsp.row_end     = out_row_end_q;
	assign rsp.last        = out_last_q;

endmodule

[design/nearest_neighbor_scale_address_gen.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_gen
// Source address generator for a nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
// One request beat per destination pixel, in row-major order, gives one result
// beat with the source address to fetch, the linear destination index and the
// row and frame end flags. The block takes one beat per clock and delivers one
// per clock when the result side keeps up; a beat is held in the request queue
// and then registered in the step engine before it reaches the result channel,
// and the step engine's update of the counters and remainder accumulators for
// each beat it takes sets the rate. A set restart field begins a new frame at
// start_offset before that pixel, and a frame also restarts by itself after
// its last pixel. Write registers only while no beats are in flight.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_gen import nnsag_pkg::*; #(
	parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
	parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nnsag_cfg_if.sink   cfg,
	nnsag_in_if.sink    req,
	nnsag_out_if.source rsp
);

	nnsag_cfg_t  cfg_q;
	nnsag_head_t head;
	logic        pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width    <= RST_SRC_WIDTH;
			cfg_q.dst_width    <= RST_DST_WIDTH;
			cfg_q.dst_height   <= RST_DST_HEIGHT;
			cfg_q.x_step_whole <= RST_X_STEP_WHOLE;
			cfg_q.x_step_rem   <= RST_X_STEP_REM;
			cfg_q.row_skip     <= RST_ROW_SKIP;
			cfg_q.y_step_rem   <= RST_Y_STEP_REM;
			cfg_q.start_offset <= RST_START_OFFSET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SRC_WIDTH:    cfg_q.src_width    <= cfg.data[DIM_W-1:0];
				REG_DST_WIDTH:    cfg_q.dst_width    <= cfg.data[DIM_W-1:0];
				REG_DST_HEIGHT:   cfg_q.dst_height   <= cfg.data[DIM_W-1:0];
				REG_X_STEP_WHOLE: cfg_q.x_step_whole <= cfg.data[DIM_W-1:0];
				REG_X_STEP_REM:   cfg_q.x_step_rem   <= cfg.data[REM_W-1:0];
				REG_ROW_SKIP:     cfg_q.row_skip     <= cfg.data[SKIP_W-1:0];
				REG_Y_STEP_REM:   cfg_q.y_step_rem   <= cfg.data[REM_W-1:0];
				REG_START_OFFSET: cfg_q.start_offset <= cfg.data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nnsag_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	nnsag_step #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("step engine took a beat from an empty queue");

	a_pop_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !req.ready |=> req.ready)
		else $error("queue stayed full after a pop");

	a_idle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && !head.valid && !rsp.valid |-> ##2 rsp.valid)
		else $error("result beat missing two cycles after accept into idle block");
`endif

endmodule
